/* rtl/mda_pkg.sv */
// Shared widths and codes for the multichannel decimating averager.
package mda_pkg;

    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int OS_W     = 5;
    localparam int TIME_W   = 64;
    localparam int GS_W     = 11;
    localparam int LOC_W    = 2;
    localparam int TICK_W   = 32;
    localparam int FAC_W    = 16;
    localparam int PROD_W   = TICK_W + FAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [LOC_W-1:0]     t_loc;

    localparam t_cfg_idx CFG_GROUP_SIZE = 2'd0;
    localparam t_cfg_idx CFG_STAMP_LOC  = 2'd1;
    localparam t_cfg_idx CFG_TICK       = 2'd2;

    localparam t_loc LOC_START  = 2'd0;
    localparam t_loc LOC_MIDDLE = 2'd1;
    localparam t_loc LOC_END    = 2'd2;

    localparam logic [GS_W-1:0]   GROUP_SIZE_RST = 11'd1;
    localparam logic [TICK_W-1:0] TICK_RST       = 32'd744319;

endpackage

/* rtl/multichannel_decimating_averager.sv */
// Multichannel boxcar decimating averager: top level.
//
// Accepts one sample beat per channel and sums it into that channel's
// accumulator; when a channel has collected group_size samples it delivers
// the sum divided by group_size * oversample (truncated) and the timestamp of
// the group's first sample plus a rounded start/middle/end offset. A sample
// that does not close a group is accepted, then goes through a read-modify-write
// of the per-channel store. A sample that closes a group goes through the
// offset multiply, the timestamp add and the bit-serial restoring divider,
// which yields SUM_W quotient bits, one quotient bit per cycle, with SUM_W =
// 16 + clog2(min(MAX_GROUP, 2047) + 1) (27 at the defaults). Input stall is
// high for the whole of that work, and also while a finished result waits for
// a full output register. Writing group_size clears every channel's sum and
// count.
module multichannel_decimating_averager #(
    parameter int CHANNELS  = 16,
    parameter int MAX_GROUP = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mda_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mda_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mda_pkg::CH_W-1:0]           i_channel,
    input  logic [mda_pkg::SAMPLE_W-1:0]       i_sample_value,
    input  logic [mda_pkg::OS_W-1:0]           i_oversample,
    input  logic [mda_pkg::TIME_W-1:0]         i_sample_time_ns,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mda_pkg::CH_W-1:0]           o_out_channel,
    output logic [mda_pkg::SAMPLE_W-1:0]       o_mean_value,
    output logic [mda_pkg::TIME_W-1:0]         o_out_time_ns
);

    localparam int GMAX   = (MAX_GROUP < 2047) ? MAX_GROUP : 2047;
    localparam int CNT_W  = (GMAX > 1) ? $clog2(GMAX + 1) : 1;
    localparam int SUM_W  = mda_pkg::SAMPLE_W + CNT_W;
    localparam int DEPTH  = (CHANNELS < 16) ? CHANNELS : 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration
    logic [mda_pkg::GS_W-1:0]   r_group_size;
    mda_pkg::t_loc              r_loc;
    logic [mda_pkg::TICK_W-1:0] r_tick;

    // sequencer
    logic [2:0] r_state, n_state;
    logic [STEP_W-1:0] r_step;

    // latched beat
    logic [mda_pkg::CH_W-1:0]     r_ch;
    logic [IDX_W-1:0]             r_idx;
    logic [mda_pkg::SAMPLE_W-1:0] r_sample;
    logic [mda_pkg::OS_W-1:0]     r_os;
    logic [mda_pkg::TIME_W-1:0]   r_stamp;

    // per-channel store
    logic [SUM_W-1:0]           r_sum_mem  [DEPTH];
    logic [CNT_W-1:0]           r_cnt_mem  [DEPTH];
    logic [mda_pkg::TIME_W-1:0] r_time_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [SUM_W-1:0]           r_sum_rd;
    logic [CNT_W-1:0]           r_cnt_rd;
    logic [mda_pkg::TIME_W-1:0] r_time_rd;

    // datapath
    logic [mda_pkg::TIME_W-1:0]   r_start;
    logic [mda_pkg::FAC_W-1:0]    r_fac;
    logic [mda_pkg::PROD_W-1:0]   r_prod;
    logic [mda_pkg::TIME_W-1:0]   r_time;
    logic [SUM_W-1:0]             r_quo;
    logic [mda_pkg::FAC_W-1:0]    r_rem;

    // output register
    logic                         r_out_valid;
    logic [mda_pkg::CH_W-1:0]     r_out_ch;
    logic [mda_pkg::SAMPLE_W-1:0] r_out_mean;
    logic [mda_pkg::TIME_W-1:0]   r_out_time;

    logic                         in_acc;
    logic                         ch_ok;
    logic [IDX_W-1:0]             in_idx;
    logic [mda_pkg::GS_W-1:0]     grp_eff;
    logic [mda_pkg::OS_W-1:0]     os_eff;
    logic [CNT_W-1:0]             cnt_cur;
    logic [CNT_W-1:0]             cnt_new;
    logic [SUM_W-1:0]             sum_cur;
    logic [SUM_W-1:0]             sum_new;
    logic                         grp_full;
    logic [mda_pkg::PROD_W:0]     rnd_sum;
    logic [mda_pkg::TIME_W-1:0]   offset;
    logic [mda_pkg::FAC_W:0]      trial;
    logic [mda_pkg::FAC_W:0]      trial_diff;
    logic                         out_free;

    assign o_in_stall    = (r_state != S_IDLE);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign ch_ok         = (9'(i_channel) < 9'(CHANNELS));
    assign in_idx        = i_channel[IDX_W-1:0];
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_mean_value  = r_out_mean;
    assign o_out_time_ns = r_out_time;
    assign out_free      = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_group_size == '0) begin
            grp_eff = mda_pkg::GS_W'(1);
        end else if (17'(r_group_size) > 17'(MAX_GROUP)) begin
            grp_eff = mda_pkg::GS_W'(MAX_GROUP);
        end else begin
            grp_eff = r_group_size;
        end
    end

    assign os_eff   = (r_os == '0) ? mda_pkg::OS_W'(1) : r_os;
    assign cnt_cur  = r_vld[r_idx] ? r_cnt_rd : '0;
    assign sum_cur  = r_vld[r_idx] ? r_sum_rd : '0;
    assign cnt_new  = cnt_cur + CNT_W'(1);
    assign sum_new  = sum_cur + SUM_W'(r_sample);
    assign grp_full = !(cnt_new < CNT_W'(grp_eff));

    // round half up, then drop the Q16 fraction (and one more bit for middle)
    assign rnd_sum = {1'b0, r_prod} +
                     ((r_loc == mda_pkg::LOC_MIDDLE) ? (mda_pkg::PROD_W+1)'(32'h10000)
                                                     : (mda_pkg::PROD_W+1)'(32'h8000));
    always_comb begin
        case (r_loc)
            mda_pkg::LOC_MIDDLE: offset = mda_pkg::TIME_W'(rnd_sum[mda_pkg::PROD_W:17]);
            mda_pkg::LOC_END:    offset = mda_pkg::TIME_W'(rnd_sum[mda_pkg::PROD_W:16]);
            default:             offset = '0;
        endcase
    end

    // one restoring-divide step
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_fac};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && ch_ok) n_state = S_ACC;
            S_ACC:  n_state = grp_full ? S_MUL : S_IDLE;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_DIV;
            S_DIV:  if (r_step == '0) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_group_size <= mda_pkg::GROUP_SIZE_RST;
            r_loc        <= mda_pkg::LOC_START;
            r_tick       <= mda_pkg::TICK_RST;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mda_pkg::CFG_GROUP_SIZE: begin
                        r_group_size <= i_cfg_data[mda_pkg::GS_W-1:0];
                        r_vld        <= '0;
                    end
                    mda_pkg::CFG_STAMP_LOC: r_loc  <= i_cfg_data[mda_pkg::LOC_W-1:0];
                    mda_pkg::CFG_TICK:      r_tick <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                r_vld[r_idx] <= !grp_full;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // store and datapath, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch      <= i_channel;
            r_idx     <= in_idx;
            r_sample  <= i_sample_value;
            r_os      <= i_oversample;
            r_stamp   <= i_sample_time_ns;
            r_sum_rd  <= r_sum_mem[in_idx];
            r_cnt_rd  <= r_cnt_mem[in_idx];
            r_time_rd <= r_time_mem[in_idx];
        end
        case (r_state)
            S_ACC: begin
                if (!grp_full) begin
                    r_sum_mem[r_idx] <= sum_new;
                    r_cnt_mem[r_idx] <= cnt_new;
                end
                if (cnt_cur == '0) begin
                    r_time_mem[r_idx] <= r_stamp;
                end
                r_start <= (cnt_cur == '0) ? r_stamp : r_time_rd;
                r_fac   <= mda_pkg::FAC_W'(grp_eff) * mda_pkg::FAC_W'(os_eff);
                r_quo   <= sum_new;
                r_rem   <= '0;
                r_step  <= STEP_W'(SUM_W - 1);
            end
            S_MUL: begin
                r_prod <= mda_pkg::PROD_W'(r_tick) *
                          mda_pkg::PROD_W'(r_fac - mda_pkg::FAC_W'(1));
            end
            S_ADD: begin
                r_time <= r_start + offset;
            end
            S_DIV: begin
                if (!trial_diff[mda_pkg::FAC_W]) begin
                    r_rem <= trial_diff[mda_pkg::FAC_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[mda_pkg::FAC_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
                r_step <= r_step - STEP_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_ch   <= r_ch;
                    r_out_mean <= r_quo[mda_pkg::SAMPLE_W-1:0];
                    r_out_time <= r_time;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ch_ok) |=> (r_state == S_ACC))
        else $error("accepted beat did not reach accumulate step");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |=> (r_state == S_DONE))
        else $error("divider did not finish after last step");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished divide");

    a_count_below_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (cnt_cur < CNT_W'(grp_eff)))
        else $error("stored count reached group size");
`endif

endmodule
